// ===== src/dfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared types and codes for the deduplicating queue: result status codes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dfq_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic       load;       // capture the item, arm the key scan
		logic       scan_step;  // read next occupied key for compare
		logic       pop_issue;  // read the head slot
		logic       push;       // store the item at the tail
		logic       pop;        // retire the head slot
		logic       finish;     // present a result
		logic [1:0] code;       // status of that result
	} dfq_cmd_t;

	typedef struct packed {
		logic cmd_read;
		logic empty;
		logic full;
		logic scan_done;
		logic hit;
	} dfq_stat_t;

endpackage

// ===== src/dfq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dfq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/dfq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_ctrl
// Sequencer for the queue: dispatches each item, walks the duplicate scan
// and decides the result status.
// ----------------------------------------------------------------------------
module dfq_ctrl
	import dfq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dfq_stat_t stat,
	output dfq_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_DISPATCH = 2'd1;
	localparam logic [1:0] S_SCAN     = 2'd2;
	localparam logic [1:0] S_POP      = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.code  = ST_OK;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.cmd_read) begin
					if (stat.empty) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_EMPTY;
						state_nxt  = S_IDLE;
					end else begin
						cmd.pop_issue = 1'b1;
						state_nxt     = S_POP;
					end
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				// A hit always wins, even on a full queue.
				if (stat.hit) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_DUP;
					state_nxt  = S_IDLE;
				end else if (stat.scan_done) begin
					cmd.finish = 1'b1;
					if (stat.full) begin
						cmd.code = ST_FULL;
					end else begin
						cmd.push = 1'b1;
						cmd.code = ST_OK;
					end
					state_nxt = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_POP: begin
				cmd.pop    = 1'b1;
				cmd.finish = 1'b1;
				cmd.code   = ST_OK;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/dfq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_datapath
// Queue storage, ring pointers, occupancy count, the key comparator of the
// duplicate scan and the result registers.
// ----------------------------------------------------------------------------
module dfq_datapath
	import dfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dfq_cmd_t    cmd,
	output dfq_stat_t   stat,
	input  logic        command,
	input  logic [63:0] entry_key,
	input  logic [63:0] entry_payload,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] out_key,
	output logic [63:0] out_payload,
	output logic [4:0]  occupancy
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

	logic          cmd_q;
	logic [63:0]   key_q;
	logic [63:0]   payload_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_ptr_q;
	logic [CW-1:0] scan_left_q;
	logic          cmp_vld_q;

	logic [IW-1:0] rd_addr;
	logic [63:0]   rd_key;
	logic [63:0]   rd_payload;
	logic [CW-1:0] count_nxt;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] slot);
		return (slot == LAST_SLOT) ? '0 : slot + IW'(1);
	endfunction

	assign rd_addr = cmd.pop_issue ? head_q : scan_ptr_q;

	dfq_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (rd_key)
	);

	dfq_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_payload_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (payload_q),
		.raddr (rd_addr),
		.rdata (rd_payload)
	);

	assign stat.cmd_read  = (cmd_q == CMD_READ);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == FULL_CNT);
	assign stat.scan_done = (scan_left_q == '0);
	assign stat.hit       = cmp_vld_q && (rd_key == key_q);

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			key_q     <= entry_key;
			payload_q <= entry_payload;
		end
	end

	// The scan walks every occupied slot from the head; each read is
	// compared in the following cycle, when its data comes back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			cmp_vld_q   <= 1'b0;
			done        <= 1'b0;
		end else begin
			count_q   <= count_nxt;
			cmp_vld_q <= cmd.scan_step;
			done      <= cmd.finish;
			if (cmd.push) begin
				tail_q <= next_slot(tail_q);
			end
			if (cmd.pop) begin
				head_q <= next_slot(head_q);
			end
			if (cmd.load) begin
				scan_ptr_q  <= head_q;
				scan_left_q <= count_q;
			end else if (cmd.scan_step) begin
				scan_ptr_q  <= next_slot(scan_ptr_q);
				scan_left_q <= scan_left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status      <= cmd.code;
			out_key     <= cmd.pop ? rd_key : '0;
			out_payload <= cmd.pop ? rd_payload : '0;
			occupancy   <= 5'(count_nxt);
		end
	end

endmodule

// ===== src/dedup_fifo_queue.sv =====
`timescale 1ns / 1ps
// A read gives its result after the dispatch and pop states, or after dispatch alone
// on an empty queue; a write first runs the duplicate scan, which reads one stored key
// per cycle from the key memory (a hit ends the scan early).
// Throughput: one item at a time; the next start is taken at the edge that ends done.
// Reset (arst_n low) empties the queue; the results cannot be stalled.
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// First-in first-out queue of keyed entries that rejects a write whose key
// matches an entry already held, with full and empty status.
// ----------------------------------------------------------------------------
module dedup_fifo_queue
	import dfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [63:0] entry_key,
	input  logic [63:0] entry_payload,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] out_key,
	output logic [63:0] out_payload,
	output logic [4:0]  occupancy
);

	dfq_cmd_t  cmd;
	dfq_stat_t stat;

	dfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	dfq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.done          (done),
		.status        (status),
		.out_key       (out_key),
		.out_payload   (out_payload),
		.occupancy     (occupancy)
	);

endmodule

// ===== dv/dfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_checker
// Watches the command and result ports of the deduplicating queue, keeps a
// shadow copy of the queue contents, and compares every result with the
// status, popped entry and occupancy that the shadow copy predicts.
// ----------------------------------------------------------------------------
module dfq_checker
	import dfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        command,
	input  logic [63:0] entry_key,
	input  logic [63:0] entry_payload,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [63:0] out_key,
	input  logic [63:0] out_payload,
	input  logic [4:0]  occupancy,
	output int          error_count,
	output int          awaiting,
	output int          ok_count,
	output int          dup_count,
	output int          full_count,
	output int          empty_count
);

	localparam int PEND_DEPTH = 8;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] key;
		logic [63:0] payload;
		logic [4:0]  occupancy;
	} queue_result_t;

	logic [63:0]   shadow_keys [QUEUE_DEPTH];
	logic [63:0]   shadow_payloads [QUEUE_DEPTH];
	int unsigned   head_slot;
	int unsigned   tail_slot;
	int unsigned   held_count;
	queue_result_t expected_results [PEND_DEPTH];
	int unsigned   pend_rd;
	int unsigned   pend_wr;

	// Only occupied slots take part in the duplicate search.
	function automatic bit key_is_held(input logic [63:0] key);
		int unsigned slot;
		slot = head_slot;
		for (int unsigned n = 0; n < held_count; n++) begin
			if (shadow_keys[slot] == key)
				return 1'b1;
			slot = (slot + 1) % QUEUE_DEPTH;
		end
		return 1'b0;
	endfunction

	task automatic apply_queue_op(input logic cmd, input logic [63:0] key,
			input logic [63:0] payload, output queue_result_t res);
		res = '0;
		res.status = ST_OK;
		if (cmd == CMD_WRITE) begin
			// The duplicate check wins over the full check.
			if (key_is_held(key)) begin
				res.status = ST_DUP;
			end else if (held_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				shadow_keys[tail_slot] = key;
				shadow_payloads[tail_slot] = payload;
				tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.key = shadow_keys[head_slot];
				res.payload = shadow_payloads[head_slot];
				head_slot = (head_slot + 1) % QUEUE_DEPTH;
				held_count--;
			end
		end
		res.occupancy = held_count[4:0];
	endtask

	task automatic report_field(input string field_name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, field_name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		queue_result_t item_res;
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			held_count = 0;
			pend_rd = 0;
			pend_wr = 0;
			awaiting = 0;
		end else begin
			if (done) begin
				if (pend_wr == pend_rd) begin
					$display("%0t: result with no item outstanding: status %0d key %h payload %h",
						$time, status, out_key, out_payload);
					error_count++;
				end else begin
					want = expected_results[pend_rd % PEND_DEPTH];
					pend_rd++;
					report_field("status", 64'(want.status), 64'(status));
					report_field("out_key", want.key, out_key);
					report_field("out_payload", want.payload, out_payload);
					report_field("occupancy", 64'(want.occupancy), 64'(occupancy));
				end
			end
			if (start && !busy) begin
				apply_queue_op(command, entry_key, entry_payload, item_res);
				if (pend_wr - pend_rd >= PEND_DEPTH) begin
					$display("%0t: too many items without a result", $time);
					error_count++;
				end else begin
					expected_results[pend_wr % PEND_DEPTH] = item_res;
					pend_wr++;
				end
				case (item_res.status)
					ST_OK: ok_count++;
					ST_DUP: dup_count++;
					ST_FULL: full_count++;
					default: empty_count++;
				endcase
			end
			awaiting = int'(pend_wr - pend_rd);
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the deduplicating queue with a directed opening (empty read, extreme
// keys, duplicates, full queue) and then random bursts of writes and reads
// with keys often reused; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb;
	import dfq_pkg::*;

	localparam int QUEUE_DEPTH    = 16;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int KEY_POOL       = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 25;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        command = CMD_WRITE;
	logic [63:0] entry_key = '0;
	logic [63:0] entry_payload = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [63:0] out_key;
	logic [63:0] out_payload;
	logic [4:0]  occupancy;

	int          error_count;
	int          awaiting;
	int          ok_count;
	int          dup_count;
	int          full_count;
	int          empty_count;
	int          items_sent = 0;
	int          stall_cycles = 0;
	logic [63:0] recent_keys [KEY_POOL];
	int          pool_wr = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dedup_fifo_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_key    (entry_key),
		.entry_payload(entry_payload),
		.done         (done),
		.status       (status),
		.out_key      (out_key),
		.out_payload  (out_payload),
		.occupancy    (occupancy)
	);

	dfq_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_key    (entry_key),
		.entry_payload(entry_payload),
		.done         (done),
		.status       (status),
		.out_key      (out_key),
		.out_payload  (out_payload),
		.occupancy    (occupancy),
		.error_count  (error_count),
		.awaiting     (awaiting),
		.ok_count     (ok_count),
		.dup_count    (dup_count),
		.full_count   (full_count),
		.empty_count  (empty_count)
	);

	// Any cycle with no item taken and no result shown counts toward a hang.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the item is taken.
	// start is left high so that a following item goes out back to back.
	task automatic send_item(input logic cmd, input logic [63:0] key,
			input logic [63:0] payload);
		start <= 1'b1;
		command <= cmd;
		entry_key <= key;
		entry_payload <= payload;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (cmd == CMD_WRITE) begin
			recent_keys[pool_wr] = key;
			pool_wr = (pool_wr + 1) % KEY_POOL;
		end
	endtask

	// Reused keys make duplicates and rewrites of freed keys common.
	function automatic logic [63:0] pick_key();
		logic [63:0] key;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			key = recent_keys[$urandom_range(0, KEY_POOL - 1)];
		end else if (roll < 50) begin
			case ($urandom_range(0, 3))
				0: key = '0;
				1: key = '1;
				2: key = 64'd1 << $urandom_range(0, 63);
				default: key = ~(64'd1 << $urandom_range(0, 63));
			endcase
		end else begin
			key = {$urandom, $urandom};
		end
		return key;
	endfunction

	initial begin
		int   sent_random;
		int   burst_len;
		int   read_pct;
		int   gap;
		logic cmd;
		logic [63:0] key;

		foreach (recent_keys[i])
			recent_keys[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty read, extreme keys, a duplicate, then a full
		// queue hit by a duplicate and by a fresh key, then two pops.
		send_item(CMD_READ, '1, '1);
		send_item(CMD_WRITE, '0, '1);
		send_item(CMD_WRITE, '1, '0);
		send_item(CMD_WRITE, '0, 64'h1234_5678_9ABC_DEF0);
		send_item(CMD_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_item(CMD_WRITE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		for (int i = 0; i < QUEUE_DEPTH - 4; i++)
			send_item(CMD_WRITE, 64'h0123_4567_89AB_0000 + i, ~(64'h0123_4567_89AB_0000 + i));
		send_item(CMD_WRITE, '1, 64'h0F0F_0F0F_0F0F_0F0F);
		send_item(CMD_WRITE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
		send_item(CMD_READ, '0, '0);
		send_item(CMD_READ, '0, '0);

		// Random bursts, each leaning toward writes, reads or neither, so the
		// queue swings between empty and full many times.
		sent_random = 0;
		while (sent_random < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 40);
			case ($urandom_range(0, 2))
				0: read_pct = 15;
				1: read_pct = 85;
				default: read_pct = 45;
			endcase
			for (int i = 0; i < burst_len; i++) begin
				cmd = ($urandom_range(0, 99) < read_pct) ? CMD_READ : CMD_WRITE;
				key = pick_key();
				send_item(cmd, key, {$urandom, $urandom});
				sent_random++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		start <= 1'b0;
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d completed, %0d duplicate rejects, %0d full rejects,",
			items_sent, ok_count, dup_count, full_count);
		$display("and %0d reads of an empty queue; %0d field errors seen.",
			empty_count, error_count);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
